[rtl/iiel_pkg.sv]
// Shared types and defaults for the indexed insert/erase list.
// Used by the front, back and top modules; depends on nothing else.
package iiel_pkg;

  // default list size and element word width
  localparam int IIEL_CAPACITY      = 32;
  localparam int IIEL_ELEMENT_WIDTH = 32;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } st_t;

  // work the back end has to carry out for one request
  typedef enum logic [2:0] {
    K_NONE  = 3'd0,
    K_WRITE = 3'd1,
    K_INS   = 3'd2,
    K_ERA   = 3'd3,
    K_READ  = 3'd4
  } cmd_kind_t;

  // classified request control, passed from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    st_t        status;
    logic [5:0] count;
    logic       is_empty;
  } cmd_ctl_t;

  // one result beat
  typedef struct packed {
    logic [31:0] read_element;
    st_t         status;
    logic [5:0]  count;
    logic        is_empty;
  } res_t;

endpackage

[rtl/indexed_insert_erase_list_top.sv]
// Top level of the indexed insert/erase list: front end, command queue and
// back end. Depends on iiel_pkg, iiel_front, iiel_fifo and iiel_back.
//
// Ordered list of up to CAPACITY element words with append, insert, erase,
// read at a position, read first and read last; every request beat returns
// one result beat with the element read, a status, the count and an empty
// flag. The front end checks each request against its own running count at
// accept time and queues up to two commands, so requests are taken while the
// back end is still busy. The back end works through an entry memory with
// one read and one write port that moves one entry per cycle; insert and
// erase shift every entry behind their position, so those near the front of
// a long list set the sustained rate. Results also wait on m_tready. Refused
// requests (range, empty, full) and unused operation codes leave the list
// unchanged.
module indexed_insert_erase_list_top import iiel_pkg::*; #(
  parameter int CAPACITY      = IIEL_CAPACITY,
  parameter int ELEMENT_WIDTH = IIEL_ELEMENT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // operation[2:0], position[8:3], element[40:9]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // read_element[31:0], status[33:32],
                                // count[39:34], is_empty[40]
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int QW = $bits(cmd_ctl_t) + AW + CW + ELEMENT_WIDTH;

  cmd_ctl_t                 f_ctl;
  logic [AW-1:0]            f_lo;
  logic [CW-1:0]            f_hi;
  logic [ELEMENT_WIDTH-1:0] f_elem;
  logic                     f_valid;
  logic                     f_ready;

  cmd_ctl_t                 b_ctl;
  logic [AW-1:0]            b_lo;
  logic [CW-1:0]            b_hi;
  logic [ELEMENT_WIDTH-1:0] b_elem;
  logic                     b_valid;
  logic                     b_ready;
  logic [QW-1:0]            b_data;

  res_t                     res;

  // request classification
  iiel_front #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .operation (s_tdata[2:0]),
    .position  (s_tdata[8:3]),
    .element   (s_tdata[40:9]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .ctl       (f_ctl),
    .lo        (f_lo),
    .hi        (f_hi),
    .elem      (f_elem)
  );

  // command queue
  iiel_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   ({f_ctl, f_lo, f_hi, f_elem}),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  assign {b_ctl, b_lo, b_hi, b_elem} = b_data;

  // execution on the entry memory
  iiel_back #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_ctl     (b_ctl),
    .q_lo      (b_lo),
    .q_hi      (b_hi),
    .q_elem    (b_elem),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // result beat packing
  assign m_tdata = {7'd0, res.is_empty, res.count, res.status, res.read_element};

endmodule

[rtl/iiel_front.sv]
// Front end: takes request beats, checks them against the running count and
// turns them into back-end commands. Depends on iiel_pkg.
module iiel_front import iiel_pkg::*; #(
  parameter int CAPACITY      = IIEL_CAPACITY,
  parameter int ELEMENT_WIDTH = IIEL_ELEMENT_WIDTH,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               operation,
  input  logic [5:0]               position,
  input  logic [31:0]              element,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cmd_ctl_t                 ctl,
  output logic [AW-1:0]            lo,
  output logic [CW-1:0]            hi,
  output logic [ELEMENT_WIDTH-1:0] elem
);

  localparam int XW = (CW > 6) ? CW : 6;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_ERASE   = 3'd2,
    OP_READ_AT = 3'd3,
    OP_FIRST   = 3'd4,
    OP_LAST    = 3'd5
  } op_t;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          full;
  logic          empty;
  logic          take;

  assign in_ready  = out_ready;
  assign out_valid = in_valid;
  assign take      = in_valid & out_ready;

  assign pos_x = XW'(position);
  assign cnt_x = XW'(count);
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);
  assign hi    = count;
  assign elem  = ELEMENT_WIDTH'(element);

  // classify the request and work out the count it leaves behind
  always_comb begin
    ctl.kind   = K_NONE;
    ctl.status = ST_OK;
    lo         = '0;
    count_next = count;
    case (op_t'(operation))
      OP_APPEND: begin
        if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.kind   = K_WRITE;
          lo         = AW'(count);
          count_next = count + CW'(1);
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          ctl.status = ST_RANGE;
        end else if (full) begin
          ctl.status = ST_FULL;
        end else begin
          ctl.kind   = K_INS;
          lo         = AW'(position);
          count_next = count + CW'(1);
        end
      end
      OP_ERASE: begin
        if (pos_x >= cnt_x) begin
          ctl.status = ST_RANGE;
        end else begin
          ctl.kind   = K_ERA;
          lo         = AW'(position);
          count_next = count - CW'(1);
        end
      end
      OP_READ_AT: begin
        if (pos_x >= cnt_x) begin
          ctl.status = ST_RANGE;
        end else begin
          ctl.kind = K_READ;
          lo       = AW'(position);
        end
      end
      OP_FIRST: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.kind = K_READ;
        end
      end
      OP_LAST: begin
        if (empty) begin
          ctl.status = ST_EMPTY;
        end else begin
          ctl.kind = K_READ;
          lo       = AW'(count - CW'(1));
        end
      end
      default: begin
        ctl.kind = K_NONE;
      end
    endcase
    ctl.count    = 6'(count_next);
    ctl.is_empty = (count_next == '0);
  end

  // running entry count, tracked at accept time
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (take) begin
      count <= count_next;
    end
  end

endmodule

[rtl/iiel_fifo.sv]
// Two-entry command queue between the front and back ends.
// Generic payload width; no package dependencies.
module iiel_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slot[rptr];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= in_data;
    end
  end

endmodule

[rtl/iiel_back.sv]
// Back end: executes commands on the entry memory (shifts, writes, reads)
// and holds the result beat in an output register. Depends on iiel_pkg.
module iiel_back import iiel_pkg::*; #(
  parameter int CAPACITY      = IIEL_CAPACITY,
  parameter int ELEMENT_WIDTH = IIEL_ELEMENT_WIDTH,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_valid,
  output logic                     q_ready,
  input  cmd_ctl_t                 q_ctl,
  input  logic [AW-1:0]            q_lo,
  input  logic [CW-1:0]            q_hi,
  input  logic [ELEMENT_WIDTH-1:0] q_elem,
  output logic                     out_valid,
  input  logic                     out_ready,
  output res_t                     out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOVE,
    S_PUT,
    S_READ,
    S_DONE
  } state_t;

  logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] rdata;

  state_t                   state;
  cmd_ctl_t                 ctl;
  logic [AW-1:0]            lo;
  logic [ELEMENT_WIDTH-1:0] elem;
  logic [AW-1:0]            src;
  logic [CW-1:0]            n;
  logic                     pipe_valid;
  logic [AW-1:0]            pipe_dst;
  logic [31:0]              rd_word;

  logic                     up;
  logic [CW-1:0]            span;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;

  assign q_ready = (state == S_IDLE);
  assign up      = (ctl.kind == K_INS);
  assign span    = q_hi - CW'(q_lo);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = src;
    wr_en   = 1'b0;
    wr_addr = lo;
    wr_data = elem;
    if (state == S_IDLE && q_valid && q_ctl.kind == K_READ) begin
      rd_en   = 1'b1;
      rd_addr = q_lo;
    end else if (state == S_MOVE && n != '0) begin
      rd_en = 1'b1;
    end
    if (state == S_MOVE && pipe_valid) begin
      wr_en   = 1'b1;
      wr_addr = pipe_dst;
      wr_data = rdata;
    end else if (state == S_PUT) begin
      wr_en = 1'b1;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // command sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pipe_valid <= 1'b0;
    end else begin
      // result taken with no new one to load behind it
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            ctl     <= q_ctl;
            lo      <= q_lo;
            elem    <= q_elem;
            rd_word <= '0;
            case (q_ctl.kind)
              K_WRITE: state <= S_PUT;
              K_READ:  state <= S_READ;
              K_INS: begin
                src   <= AW'(q_hi - CW'(1));
                n     <= span;
                state <= (span == '0) ? S_PUT : S_MOVE;
              end
              K_ERA: begin
                src   <= q_lo + AW'(1);
                n     <= span - CW'(1);
                state <= (span == CW'(1)) ? S_DONE : S_MOVE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_MOVE: begin
          // one entry moves per cycle: read now, write next cycle
          pipe_valid <= (n != '0);
          if (n != '0) begin
            pipe_dst <= up ? src + AW'(1) : src - AW'(1);
            src      <= up ? src - AW'(1) : src + AW'(1);
            n        <= n - CW'(1);
          end else if (!pipe_valid) begin
            state <= up ? S_PUT : S_DONE;
          end
        end
        S_PUT: begin
          state <= S_DONE;
        end
        S_READ: begin
          rd_word <= 32'(rdata);
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_res.read_element <= rd_word;
            out_res.status       <= ctl.status;
            out_res.count        <= ctl.count;
            out_res.is_empty     <= ctl.is_empty;
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[test/testbench.sv]
// Self-checking bench for indexed_insert_erase_list_top: drives request beats,
// keeps a shadow copy of the list and checks every result beat against it.
// Depends on iiel_pkg and the RTL of the list; reads no files.
module testbench import iiel_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // request operation codes as carried in the low bits of s_tdata
  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_INSERT     = 3'd1,
    OP_ERASE      = 3'd2,
    OP_READ_AT    = 3'd3,
    OP_READ_FIRST = 3'd4,
    OP_READ_LAST  = 3'd5,
    OP_SPARE6     = 3'd6,
    OP_SPARE7     = 3'd7
  } list_op_t;

  // random stimulus leanings
  typedef enum int {
    LEAN_GROW,
    LEAN_SHRINK,
    LEAN_MIXED
  } lean_t;

  localparam int RANDOM_BEATS = 1080;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;

  // shadow of the list contents; predicts one result per accepted request
  class list_shadow;
    logic [31:0] slots [IIEL_CAPACITY];
    int          fill;
    res_t        awaited_results[$];
    int          mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // apply one accepted request to the shadow and queue its result
    function void take_request(list_op_t op, logic [5:0] pos, logic [31:0] elem);
      res_t r;
      int   j;
      r.read_element = '0;
      r.status       = ST_OK;
      case (op)
        OP_APPEND: begin
          if (fill >= IIEL_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slots[fill] = elem;
            fill++;
          end
        end
        OP_INSERT: begin
          // past-the-end check wins over the full check
          if (int'(pos) > fill) begin
            r.status = ST_RANGE;
          end else if (fill >= IIEL_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (j = fill; j > int'(pos); j--) slots[j] = slots[j-1];
            slots[pos] = elem;
            fill++;
          end
        end
        OP_ERASE: begin
          if (int'(pos) >= fill) begin
            r.status = ST_RANGE;
          end else begin
            for (j = int'(pos) + 1; j < fill; j++) slots[j-1] = slots[j];
            fill--;
          end
        end
        OP_READ_AT: begin
          if (int'(pos) >= fill) r.status = ST_RANGE;
          else r.read_element = slots[pos];
        end
        OP_READ_FIRST: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.read_element = slots[0];
        end
        OP_READ_LAST: begin
          if (fill == 0) r.status = ST_EMPTY;
          else r.read_element = slots[fill-1];
        end
        default: begin
          // unused codes leave the list alone and report ok
        end
      endcase
      r.count    = fill[5:0];
      r.is_empty = (fill == 0);
      awaited_results = {awaited_results, r};
    endfunction

    // compare one result beat with the oldest prediction
    function void match_result(logic [47:0] beat);
      res_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing outstanding: %h", beat);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      if (beat[31:0] !== want.read_element) begin
        $error("read_element: expected %h, got %h", want.read_element, beat[31:0]);
        mismatches++;
      end
      if (beat[33:32] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, beat[33:32]);
        mismatches++;
      end
      if (beat[39:34] !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, beat[39:34]);
        mismatches++;
      end
      if (beat[40] !== want.is_empty) begin
        $error("is_empty: expected %0d, got %0d", want.is_empty, beat[40]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  list_shadow shadow = new();
  bit         hold_req   = 1'b0;
  int         burst_left = 0;

  indexed_insert_erase_list_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // present one request beat and hold it until accepted
  task automatic send_item(input list_op_t op, input logic [5:0] pos,
                           input logic [31:0] elem);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, elem, pos, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shadow.take_request(op, pos, elem);
  endtask

  // bursty sender: random gap whenever the current burst runs out
  task automatic offer(input list_op_t op, input logic [5:0] pos,
                       input logic [31:0] elem);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_item(op, pos, elem);
  endtask

  // stop offering until every outstanding result has come back
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
    burst_left = 0;
  endtask

  // pick one random request, leaning toward growth, shrinkage or neither
  task automatic random_request(input lean_t lean, output list_op_t op,
                                output logic [5:0] pos, output logic [31:0] elem);
    int r;
    int cnt;
    r   = $urandom_range(0, 99);
    cnt = shadow.fill;
    case (lean)
      LEAN_GROW:   op = (r < 40) ? OP_APPEND : (r < 70) ? OP_INSERT :
                        (r < 78) ? OP_ERASE : OP_READ_AT;
      LEAN_SHRINK: op = (r < 10) ? OP_APPEND : (r < 20) ? OP_INSERT :
                        (r < 65) ? OP_ERASE : OP_READ_AT;
      default:     op = (r < 20) ? OP_APPEND : (r < 40) ? OP_INSERT :
                        (r < 60) ? OP_ERASE : OP_READ_AT;
    endcase
    // spread the read share over the read kinds and the spare codes
    if (op == OP_READ_AT) begin
      r = $urandom_range(0, 19);
      op = (r < 9) ? OP_READ_AT : (r < 14) ? OP_READ_FIRST : (r < 19) ? OP_READ_LAST :
           (($urandom_range(0, 1) == 1) ? OP_SPARE6 : OP_SPARE7);
    end
    // mostly in-range positions, the rest anywhere from 0 to 32
    if ($urandom_range(0, 9) < 8) begin
      if (op == OP_INSERT) pos = 6'($urandom_range(0, cnt));
      else pos = (cnt == 0) ? 6'd0 : 6'($urandom_range(0, cnt - 1));
    end else begin
      pos = 6'($urandom_range(0, 32));
    end
    r = $urandom_range(0, 19);
    elem = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
  endtask

  // result side: one ready decision per cycle, with modes and a long hold-off
  initial begin : receiver
    int  mode;
    int  mode_left;
    int  hold_left;
    int  tick;
    bit  ready;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        case (mode)
          0:       ready = 1'b1;
          1:       ready = ($urandom_range(0, 1) == 1);
          2:       ready = ($urandom_range(0, 4) == 0);
          default: ready = (tick % 3 == 0);
        endcase
      end
      m_tready <= ready;
    end
  end

  // check every accepted result beat
  initial begin : result_monitor
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) shadow.match_result(m_tdata);
    end
  end

  // run limit
  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    list_op_t    op;
    logic [5:0]  pos;
    logic [31:0] elem;
    lean_t       lean;
    int          lean_left;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty-list refusals, edge values, middle and end positions
    offer(OP_READ_FIRST, 6'd0, 32'h0);
    offer(OP_READ_LAST, 6'd0, 32'h0);
    offer(OP_READ_AT, 6'd0, 32'h0);
    offer(OP_ERASE, 6'd0, 32'h0);
    offer(OP_INSERT, 6'd1, 32'h1111_1111);
    offer(OP_SPARE6, 6'd63, 32'hFFFF_FFFF);
    offer(OP_INSERT, 6'd0, 32'hFFFF_FFFF);
    offer(OP_APPEND, 6'd0, 32'h0);
    offer(OP_APPEND, 6'd0, 32'hA5A5_5A5A);
    offer(OP_INSERT, 6'd1, 32'h0000_0001);
    offer(OP_INSERT, 6'd4, 32'h8000_0000);
    offer(OP_INSERT, 6'd6, 32'h2222_2222);
    offer(OP_READ_AT, 6'd0, 32'h0);
    offer(OP_READ_AT, 6'd4, 32'h0);
    offer(OP_READ_AT, 6'd5, 32'h0);
    offer(OP_READ_FIRST, 6'd0, 32'h0);
    offer(OP_READ_LAST, 6'd0, 32'h0);
    offer(OP_ERASE, 6'd1, 32'h0);
    offer(OP_ERASE, 6'd3, 32'h0);
    offer(OP_ERASE, 6'd0, 32'h0);
    offer(OP_READ_AT, 6'd32, 32'h0);
    offer(OP_SPARE7, 6'd0, 32'h0);
    offer(OP_ERASE, 6'd5, 32'h0);
    offer(OP_READ_LAST, 6'd0, 32'h0);

    // random: episodes that fill, drain or churn the list
    lean      = LEAN_GROW;
    lean_left = $urandom_range(40, 80);
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (lean_left == 0) begin
        lean      = lean_t'($urandom_range(0, 2));
        lean_left = $urandom_range(20, 80);
      end
      lean_left--;
      if (n == 300 || n == 750) pause_until_drained();
      // long receiver hold-off while the sender keeps offering back to back
      if (n == 500) begin
        hold_req   = 1'b1;
        burst_left = 60;
      end
      random_request(lean, op, pos, elem);
      offer(op, pos, elem);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
